### rtl/stereo_resonant_lowpass_assert.svh
// assertion macros for the resonant low-pass block
`ifndef STEREO_RESONANT_LOWPASS_ASSERT_SVH
`define STEREO_RESONANT_LOWPASS_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRLP_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SRLP_ASSERT(lbl, prop, msg)
`define SRLP_ASSERT_NR(lbl, prop, msg)
`endif
`endif

### rtl/srlp_pkg.sv
`default_nettype none
package srlp_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int CHANNELS_DEF = 2;
  localparam int STATE_W      = 32;
  localparam int COEF_W       = 16;
  localparam int ACT_W        = 2;
  localparam int MUL_W        = COEF_W + 2;
  localparam int ACC_W        = 52;
  localparam int FRAC         = 15;
  localparam int SH_W         = ACC_W - FRAC;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int REG_IDX_W    = APB_AW - 2;

  localparam logic [ACC_W-1:0] ROUND_INIT = ACC_W'(1) << (FRAC - 1);
  localparam logic [MUL_W-1:0] COEF_ONE   = MUL_W'(1) << FRAC;

  localparam logic [REG_IDX_W-1:0] REG_CUTOFF  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_DAMPING = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE  = REG_IDX_W'(2);

  localparam logic [COEF_W-1:0] CUTOFF_RST  = COEF_W'(128);
  localparam logic [COEF_W-1:0] DAMPING_RST = COEF_W'(11585);
  localparam logic [ACT_W-1:0]  ACTIVE_RST  = ACT_W'(2);

  typedef struct packed {
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          out_channel;
    logic                          out_last;
  } out_beat_t;

  typedef struct packed {
    logic [COEF_W-1:0] cutoff;
    logic [COEF_W-1:0] damping;
    logic [ACT_W-1:0]  active;
  } cfg_t;

  typedef struct packed {
    logic                      start;
    logic                      clear;
    logic signed [MUL_W-1:0]   coef;
    logic signed [STATE_W-1:0] mcand;
  } mac_req_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SH_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if ((&v[SH_W-1:STATE_W-1]) || !(|v[SH_W-1:STATE_W-1])) begin
      r = v[STATE_W-1:0];
    end else if (v[SH_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [STATE_W-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if ((&v[STATE_W-1:SAMPLE_BITS-1]) || !(|v[STATE_W-1:SAMPLE_BITS-1])) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[STATE_W-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/srlp_regs.sv
`default_nettype none
module srlp_regs import srlp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff  <= CUTOFF_RST;
      cfg_q.damping <= DAMPING_RST;
      cfg_q.active  <= ACTIVE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CUTOFF:  cfg_q.cutoff  <= pwdata[COEF_W-1:0];
        REG_DAMPING: cfg_q.damping <= pwdata[COEF_W-1:0];
        REG_ACTIVE:  cfg_q.active  <= pwdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CUTOFF:  prdata = APB_DW'(cfg_q.cutoff);
      REG_DAMPING: prdata = APB_DW'(cfg_q.damping);
      REG_ACTIVE:  prdata = APB_DW'(cfg_q.active);
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/srlp_mac.sv
`default_nettype none
module srlp_mac import srlp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_req_t                req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [ACC_W-1:0]      acc_o
);

  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] md_q, md_d;
  logic        [MUL_W-1:0] cf_q, cf_d;
  logic        [CNT_W-1:0] cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;

  // shift-add, multiplier bit per cycle lsb first, sign bit weighs negative
  always_comb begin
    acc_d  = acc_q;
    md_d   = md_q;
    cf_d   = cf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = req_i.clear ? ROUND_INIT : acc_q;
      md_d   = ACC_W'(req_i.mcand);
      cf_d   = req_i.coef;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cf_q[0]) begin
        acc_d = (cnt_q == CNT_LAST) ? acc_q - md_q : acc_q + md_q;
      end
      md_d  = md_q <<< 1;
      cf_d  = cf_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    md_q  <= md_d;
    cf_q  <= cf_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

### rtl/stereo_resonant_lowpass.sv
// filtered beat: six products pass in turn through the bit-serial multiply-accumulate unit;
// the next beat is accepted only after this result has gone to the output register
// passed-through beat: skips the multiply-accumulate unit and goes straight to the output state
// the output register frees the input side while a result waits
// reset is asynchronous active low: state of every channel cleared, registers to defaults
`default_nettype none
`include "stereo_resonant_lowpass_assert.svh"
module stereo_resonant_lowpass import srlp_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_beat_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_beat_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [2:0] TERM_RC     = 3'd0;
  localparam logic [2:0] TERM_BAND_A = 3'd1;
  localparam logic [2:0] TERM_BAND_L = 3'd2;
  localparam logic [2:0] TERM_BAND_X = 3'd3;
  localparam logic [2:0] TERM_LOW_A  = 3'd4;
  localparam logic [2:0] TERM_LOW_B  = 3'd5;

  cfg_t                          cfg;
  mac_req_t                      mac_req;
  logic                          mac_busy;
  logic                          mac_done;
  logic signed [ACC_W-1:0]       mac_acc;

  logic [1:0]                    state_q, state_d;
  logic [2:0]                    term_q, term_d;
  logic                          ch_q, ch_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                          last_q, last_d;
  logic                          filt_q, filt_d;
  logic signed [MUL_W-1:0]       a_q, a_d;
  logic signed [STATE_W-1:0]     b_new_q, b_new_d;
  logic signed [STATE_W-1:0]     l_new_q, l_new_d;
  logic                          out_valid_q, out_valid_d;
  out_beat_t                     out_q, out_d;

  logic signed [STATE_W-1:0]     band_q [CHANNELS];
  logic signed [STATE_W-1:0]     low_q  [CHANNELS];

  logic [CH_IDX_W-1:0]           ch_idx;
  logic signed [MUL_W-1:0]       c_ext;
  logic                          in_filt;
  logic                          out_load;
  logic                          in_acc;

  srlp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srlp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .busy_o (mac_busy),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  assign ch_idx     = CH_IDX_W'(ch_q);
  assign c_ext      = MUL_W'(cfg.cutoff);
  assign in_filt    = (ACT_W'(in_data_i.channel) < cfg.active) &&
                      (32'(in_data_i.channel) < CHANNELS);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    mac_req.start = (state_q == ST_ISSUE);
    mac_req.clear = 1'b0;
    mac_req.coef  = '0;
    mac_req.mcand = '0;
    case (term_q)
      TERM_RC: begin
        mac_req.clear = 1'b1;
        mac_req.coef  = MUL_W'(cfg.damping);
        mac_req.mcand = STATE_W'(cfg.cutoff);
      end
      TERM_BAND_A: begin
        mac_req.clear = 1'b1;
        mac_req.coef  = a_q;
        mac_req.mcand = band_q[ch_idx];
      end
      TERM_BAND_L: begin
        mac_req.coef  = -c_ext;
        mac_req.mcand = low_q[ch_idx];
      end
      TERM_BAND_X: begin
        mac_req.coef  = c_ext;
        mac_req.mcand = STATE_W'(x_q);
      end
      TERM_LOW_A: begin
        mac_req.clear = 1'b1;
        mac_req.coef  = a_q;
        mac_req.mcand = low_q[ch_idx];
      end
      TERM_LOW_B: begin
        mac_req.coef  = c_ext;
        mac_req.mcand = b_new_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    ch_d        = ch_q;
    x_d         = x_q;
    last_d      = last_q;
    filt_d      = filt_q;
    a_d         = a_q;
    b_new_d     = b_new_q;
    l_new_d     = l_new_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d    = in_data_i.channel;
          x_d     = in_data_i.sample_in;
          last_d  = in_data_i.block_last;
          filt_d  = in_filt;
          term_d  = TERM_RC;
          state_d = in_filt ? ST_ISSUE : ST_OUT;
        end
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) begin
          case (term_q)
            TERM_RC:     a_d     = COEF_ONE - MUL_W'(mac_acc[2*COEF_W-1:FRAC]);
            TERM_BAND_X: b_new_d = sat_state(mac_acc[ACC_W-1:FRAC]);
            TERM_LOW_B:  l_new_d = sat_state(mac_acc[ACC_W-1:FRAC]);
            default: ;
          endcase
          if (term_q == TERM_LOW_B) begin
            state_d = ST_OUT;
          end else begin
            term_d  = term_q + 3'd1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_d.sample_out  = filt_q ? sat_sample(l_new_q) : x_q;
          out_d.out_channel = ch_q;
          out_d.out_last    = last_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_RC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    x_q     <= x_d;
    last_q  <= last_d;
    filt_q  <= filt_d;
    a_q     <= a_d;
    b_new_q <= b_new_d;
    l_new_q <= l_new_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        band_q[i] <= '0;
        low_q[i]  <= '0;
      end
    end else if (out_load && filt_q) begin
      band_q[ch_idx] <= b_new_q;
      low_q[ch_idx]  <= l_new_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SRLP_ASSERT(a_wait_mac, (state_q == ST_WAIT) |-> (mac_busy || mac_done), "mac idle while waiting")
  `SRLP_ASSERT(a_out_hold, (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT), "result overwrote pending beat")
  `SRLP_ASSERT(a_pass_direct, (in_acc && !in_filt) |=> (state_q == ST_OUT), "pass-through beat entered mac")
  `SRLP_ASSERT_NR(a_idle_mac, (!rst_ni || !(state_q == ST_IDLE && mac_busy)), "mac busy while idle")

endmodule
`default_nettype wire
